// ----- src/clpt_pkg.sv -----
// Shared types, codes and helpers for the camera line position tracker.
`default_nettype none

package clpt_pkg;

    localparam int CAPTURE_BITS_DEF = 16;
    localparam int ROW_BITS_DEF     = 10;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MID_W      = 16;
    localparam int MISS_W     = 8;
    localparam int ANGLE_W    = MID_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_ROW_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_NEAR      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOM_FAR       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MISSES    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_CYCLES    = 3'd5;

    localparam logic [15:0]       RST_TIMER_PERIOD = 16'd65535;
    localparam logic [9:0]        RST_NEAR_ROW_THR = 10'd130;
    localparam logic [15:0]       RST_NOM_NEAR     = 16'd100;
    localparam logic [15:0]       RST_NOM_FAR      = 16'd60;
    localparam logic [MISS_W-1:0] RST_MAX_MISSES   = 8'd10;
    localparam logic [15:0]       RST_ROW_CYCLES   = 16'd1000;

    localparam logic [1:0] OP_RISE = 2'd0;
    localparam logic [1:0] OP_FALL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] ST_VALID   = 2'd0;
    localparam logic [1:0] ST_LOST    = 2'd1;
    localparam logic [1:0] ST_NO_RISE = 2'd2;
    localparam logic [1:0] ST_NO_FALL = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_JUDGE,
        S_DIV
    } clpt_state_t;

    typedef struct packed {
        logic take_edge;
        logic take_tick;
        logic judge;
        logic div_start;
        logic mid_write;
    } clpt_cmd_t;

    typedef struct packed {
        logic fall_pass;
        logic mid_direct;
        logic div_done;
        logic out_busy;
    } clpt_stat_t;

    function automatic logic [1:0] band_status(
        input logic [MISS_W-1:0] misses,
        input logic [MISS_W-1:0] max_misses,
        input logic              rise_seen,
        input logic              fall_seen
    );
        logic [1:0] st;
        if (misses > max_misses)
            st = ST_LOST;
        else if (!rise_seen)
            st = ST_NO_RISE;
        else if (!fall_seen)
            st = ST_NO_FALL;
        else
            st = ST_VALID;
        return st;
    endfunction

endpackage

`default_nettype wire

// ----- src/clpt_div.sv -----
// Shift-subtract divider for the midpoint fraction, one quotient bit per cycle.
`default_nettype none

module clpt_div
    import clpt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MID_W-1:0] dividend,
    input  wire logic [MID_W-1:0] divisor,
    output logic                  done,
    output logic [MID_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(MID_W);

    logic [MID_W-1:0] rem_reg;
    logic [MID_W-1:0] quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [MID_W:0]   shifted;
    logic             take;

    // The dividend is the high word of the numerator; its low word is zero.
    // It is below the divisor, so the quotient fits in MID_W bits.
    assign shifted = {rem_reg, 1'b0};
    assign take    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MID_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= take ? MID_W'(shifted - {1'b0, divisor}) : shifted[MID_W-1:0];
            quo_reg <= {quo_reg[MID_W-2:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- src/clpt_ctrl.sv -----
// Controller state machine: input handshake and sequencing of fall judgment.
`default_nettype none

module clpt_ctrl
    import clpt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] operation,
    input  wire logic       out_ready,
    input  wire clpt_stat_t stat,
    output clpt_cmd_t       cmd
);

    clpt_state_t state_reg;
    clpt_state_t state_next;
    logic        accept;

    // A tick may not overwrite a result that is still waiting.
    assign in_ready = (state_reg == S_IDLE)
                      && (operation != OP_TICK || !stat.out_busy || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == OP_FALL)
                    state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                if (stat.fall_pass && !stat.mid_direct)
                    state_next = S_DIV;
                else
                    state_next = S_IDLE;
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.take_edge = accept && (operation == OP_RISE || operation == OP_FALL);
                cmd.take_tick = accept && operation == OP_TICK;
            end
            S_JUDGE:
            begin
                cmd.judge     = 1'b1;
                cmd.div_start = stat.fall_pass && !stat.mid_direct;
            end
            S_DIV:
            begin
                cmd.mid_write = stat.div_done;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("input ready outside idle");

    a_judge_next: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_JUDGE |=> state_reg == S_IDLE || state_reg == S_DIV)
        else $error("judge step did not finish");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_done |-> state_reg == S_DIV)
        else $error("divider finished outside division");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_tick |-> !stat.out_busy || out_ready)
        else $error("tick item would overwrite a waiting result");
`endif

endmodule

`default_nettype wire

// ----- src/clpt_dp.sv -----
// Datapath: registers, band state, width check, midpoint unit and result register.
`default_nettype none

module clpt_dp
    import clpt_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEF,
    parameter int ROW_BITS     = ROW_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire clpt_cmd_t               cmd,
    output clpt_stat_t                   stat,
    input  wire logic [1:0]              operation,
    input  wire logic [CAPTURE_BITS-1:0] capture_value,
    input  wire logic [ROW_BITS-1:0]     row_number,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   near_status,
    output logic [1:0]                   far_status,
    output logic [MID_W-1:0]             near_midpoint,
    output logic [MID_W-1:0]             far_midpoint,
    output logic signed [ANGLE_W-1:0]    angle,
    output logic                         angle_valid
);

    // Edge times hold a full timer period as well as a negative capture overrun.
    localparam int EW    = ((CAPTURE_BITS > 16) ? CAPTURE_BITS : 16) + 1;
    localparam int WM    = EW + 5;
    localparam int RC_W  = (ROW_BITS > 10) ? ROW_BITS : 10;

    logic [15:0]       timer_period_reg;
    logic [9:0]        near_row_thr_reg;
    logic [15:0]       nom_near_reg;
    logic [15:0]       nom_far_reg;
    logic [MISS_W-1:0] max_misses_reg;
    logic [15:0]       row_cycles_reg;

    logic signed [EW-1:0] begin_near_reg;
    logic signed [EW-1:0] end_near_reg;
    logic signed [EW-1:0] begin_far_reg;
    logic signed [EW-1:0] end_far_reg;
    logic [MID_W-1:0]     mid_near_reg;
    logic [MID_W-1:0]     mid_far_reg;
    logic [MISS_W-1:0]    misses_near_reg;
    logic [MISS_W-1:0]    misses_far_reg;
    logic [3:0]           seen_reg;
    logic                 band_near_reg;

    logic                 out_valid_reg;
    logic [1:0]           near_status_reg;
    logic [1:0]           far_status_reg;
    logic [MID_W-1:0]     near_mid_out_reg;
    logic [MID_W-1:0]     far_mid_out_reg;
    logic [ANGLE_W-1:0]   angle_reg;
    logic                 angle_valid_reg;

    logic signed [EW-1:0] edge_cycles;
    logic                 near_sel;

    logic signed [EW-1:0] b_sel;
    logic signed [EW-1:0] e_sel;
    logic [15:0]          nom_sel;
    logic signed [EW:0]   width;
    logic signed [EW:0]   sum;
    logic signed [WM-1:0] w_ext;
    logic signed [WM-1:0] n_ext;
    logic signed [WM-1:0] w10;
    logic signed [WM-1:0] n9;
    logic signed [WM-1:0] n11;
    logic                 sum_pos;
    logic [EW-1:0]        half;
    logic                 half_big;
    logic [MID_W-1:0]     direct_val;

    logic [1:0]           ns;
    logic [1:0]           fs;
    logic                 av;
    logic [ANGLE_W-1:0]   diff;

    logic                 div_done;
    logic [MID_W-1:0]     quotient;

    assign edge_cycles = $signed(EW'(timer_period_reg)) - $signed(EW'(capture_value));
    assign near_sel    = RC_W'(row_number) >= RC_W'(near_row_thr_reg);

    assign b_sel   = band_near_reg ? begin_near_reg : begin_far_reg;
    assign e_sel   = band_near_reg ? end_near_reg : end_far_reg;
    assign nom_sel = band_near_reg ? nom_near_reg : nom_far_reg;

    assign width = $signed({e_sel[EW-1], e_sel}) - $signed({b_sel[EW-1], b_sel});
    assign sum   = $signed({e_sel[EW-1], e_sel}) + $signed({b_sel[EW-1], b_sel});

    // Width window 0.9 to 1.1 of nominal, as 10w > 9n and 10w < 11n.
    assign w_ext = WM'(width);
    assign n_ext = $signed(WM'({1'b0, nom_sel}));
    assign w10   = (w_ext <<< 3) + (w_ext <<< 1);
    assign n9    = (n_ext <<< 3) + n_ext;
    assign n11   = (n_ext <<< 3) + (n_ext <<< 1) + n_ext;

    // A half sum at or above row_cycles would give a quotient past full scale.
    assign sum_pos    = sum > $signed((EW + 1)'(1));
    assign half       = sum[EW:1];
    assign half_big   = half >= EW'(row_cycles_reg);
    assign direct_val = sum_pos ? {MID_W{1'b1}} : {MID_W{1'b0}};

    assign stat.fall_pass  = (w10 > n9) && (w10 < n11);
    assign stat.mid_direct = !sum_pos || half_big;
    assign stat.div_done   = div_done;
    assign stat.out_busy   = out_valid_reg;

    clpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (half[MID_W-1:0]),
        .divisor  (row_cycles_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    assign ns   = band_status(misses_near_reg, max_misses_reg, seen_reg[0], seen_reg[1]);
    assign fs   = band_status(misses_far_reg, max_misses_reg, seen_reg[2], seen_reg[3]);
    assign av   = !(ns != ST_VALID && fs != ST_VALID);
    assign diff = ANGLE_W'({1'b0, mid_near_reg} - {1'b0, mid_far_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_period_reg <= RST_TIMER_PERIOD;
            near_row_thr_reg <= RST_NEAR_ROW_THR;
            nom_near_reg     <= RST_NOM_NEAR;
            nom_far_reg      <= RST_NOM_FAR;
            max_misses_reg   <= RST_MAX_MISSES;
            row_cycles_reg   <= RST_ROW_CYCLES;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMER_PERIOD: timer_period_reg <= cfg_wdata;
                CFG_NEAR_ROW_THR: near_row_thr_reg <= cfg_wdata[9:0];
                CFG_NOM_NEAR:     nom_near_reg     <= cfg_wdata;
                CFG_NOM_FAR:      nom_far_reg      <= cfg_wdata;
                CFG_MAX_MISSES:   max_misses_reg   <= cfg_wdata[MISS_W-1:0];
                CFG_ROW_CYCLES:   row_cycles_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_near_reg  <= '0;
            end_near_reg    <= '0;
            begin_far_reg   <= '0;
            end_far_reg     <= '0;
            mid_near_reg    <= '0;
            mid_far_reg     <= '0;
            misses_near_reg <= '0;
            misses_far_reg  <= '0;
            seen_reg        <= '0;
            band_near_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.take_edge)
            begin
                band_near_reg <= near_sel;
                if (operation == OP_FALL)
                begin
                    if (near_sel)
                    begin
                        end_near_reg <= edge_cycles;
                        seen_reg[1]  <= 1'b1;
                    end
                    else
                    begin
                        end_far_reg <= edge_cycles;
                        seen_reg[3] <= 1'b1;
                    end
                end
                else
                begin
                    if (near_sel)
                    begin
                        begin_near_reg <= edge_cycles;
                        seen_reg[0]    <= 1'b1;
                    end
                    else
                    begin
                        begin_far_reg <= edge_cycles;
                        seen_reg[2]   <= 1'b1;
                    end
                end
            end

            if (cmd.take_tick)
            begin
                if (ns == ST_VALID)
                    seen_reg[1:0] <= 2'b00;
                if (fs == ST_VALID)
                    seen_reg[3:2] <= 2'b00;
            end

            if (cmd.judge)
            begin
                if (!stat.fall_pass)
                begin
                    if (band_near_reg && misses_near_reg != {MISS_W{1'b1}})
                        misses_near_reg <= misses_near_reg + 1'b1;
                    if (!band_near_reg && misses_far_reg != {MISS_W{1'b1}})
                        misses_far_reg <= misses_far_reg + 1'b1;
                end
                else
                begin
                    if (band_near_reg)
                        misses_near_reg <= '0;
                    else
                        misses_far_reg <= '0;
                    if (stat.mid_direct)
                    begin
                        if (band_near_reg)
                            mid_near_reg <= direct_val;
                        else
                            mid_far_reg <= direct_val;
                    end
                end
            end

            if (cmd.mid_write)
            begin
                if (band_near_reg)
                    mid_near_reg <= quotient;
                else
                    mid_far_reg <= quotient;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.take_tick)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_tick)
        begin
            near_status_reg  <= ns;
            far_status_reg   <= fs;
            near_mid_out_reg <= (ns == ST_VALID) ? mid_near_reg : '0;
            far_mid_out_reg  <= (fs == ST_VALID) ? mid_far_reg : '0;
            angle_reg        <= av ? diff : '0;
            angle_valid_reg  <= av;
        end
    end

    assign out_valid     = out_valid_reg;
    assign near_status   = near_status_reg;
    assign far_status    = far_status_reg;
    assign near_midpoint = near_mid_out_reg;
    assign far_midpoint  = far_mid_out_reg;
    assign angle         = $signed(angle_reg);
    assign angle_valid   = angle_valid_reg;

endmodule

`default_nettype wire

// ----- src/camera_line_position_tracker_top.sv -----
// Top level of the camera line position tracker.
`default_nettype none

// Rise and fall items mark the edges of a dark line in the near or far row band;
// a tick item returns one result with each band's status, both midpoints as
// unsigned 0.16 fractions of the row, and their difference as the angle. Rise,
// tick and unused-operation items finish in idle. A fall item goes to the judge
// state, then back to idle if its width is rejected or its midpoint is clamped,
// else to the division state, where a shift-subtract divider makes the midpoint
// fraction, one of its 16 quotient bits per cycle. One item is in work at a time;
// a tick is held off only while the previous result waits to be taken.
// Configuration registers may be written only while the block is idle.
module camera_line_position_tracker_top
    import clpt_pkg::*;
#(
    parameter int CAPTURE_BITS = CAPTURE_BITS_DEF,
    parameter int ROW_BITS     = ROW_BITS_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [1:0]              operation,
    input  wire logic [CAPTURE_BITS-1:0] capture_value,
    input  wire logic [ROW_BITS-1:0]     row_number,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [1:0]                   near_status,
    output logic [1:0]                   far_status,
    output logic [MID_W-1:0]             near_midpoint,
    output logic [MID_W-1:0]             far_midpoint,
    output logic signed [ANGLE_W-1:0]    angle,
    output logic                         angle_valid,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_wdata
);

    clpt_cmd_t  cmd;
    clpt_stat_t stat;

    clpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    clpt_dp #(
        .CAPTURE_BITS (CAPTURE_BITS),
        .ROW_BITS     (ROW_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .operation     (operation),
        .capture_value (capture_value),
        .row_number    (row_number),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .near_status   (near_status),
        .far_status    (far_status),
        .near_midpoint (near_midpoint),
        .far_midpoint  (far_midpoint),
        .angle         (angle),
        .angle_valid   (angle_valid)
    );

endmodule

`default_nettype wire
